/* rtl/core/bst_pkg.sv */
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants and controller/datapath handshake types for the
// binary search table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int IDX_W           = 10;
  localparam int LAST_W          = 11;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic wr;     // store entry from input transaction
    logic load;   // capture key and clamped range
    logic issue;  // launch table read at midpoint
    logic step;   // narrow range from compare result
    logic hit;    // record match at current midpoint
    logic miss;   // record not-found result
    logic emit;   // move result into output register
  } bst_cmd_t;

  typedef struct packed {
    logic range_ok;  // first <= last for loaded range
    logic match;     // table entry equals key
    logic next_ok;   // narrowed range still non-empty
    logic out_free;  // output register can take a result
  } bst_sts_t;

endpackage

`default_nettype wire

/* rtl/core/bst_if.sv */
// ----------------------------------------------------------------------------
// bst_if
// Valid/ready channel interfaces for search requests and search results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bst_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [9:0]                entry_index;
  logic signed [31:0]        entry_value;
  logic signed [31:0]        search_key;
  logic [9:0]                range_first;
  logic signed [10:0]        range_last;

  modport source (output valid, func, entry_index, entry_value, search_key,
                  range_first, range_last, input ready);
  modport sink   (input valid, func, entry_index, entry_value, search_key,
                  range_first, range_last, output ready);
endinterface

interface bst_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [9:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

/* rtl/core/bst_ram.sv */
// ----------------------------------------------------------------------------
// bst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bst_ctrl.sv */
// ----------------------------------------------------------------------------
// bst_ctrl
// Sequencer for table writes and probe-per-cycle binary search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_ready,
  input  wire bst_pkg::bst_sts_t sts,
  output bst_pkg::bst_cmd_t      cmd
);

  import bst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_START;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_START: begin
        if (sts.range_ok) begin
          cmd.issue = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          cmd.miss  = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          cmd.step = 1'b1;
          if (sts.next_ok) begin
            cmd.issue = 1'b1;
          end else begin
            cmd.miss  = 1'b1;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bst_dp.sv */
// ----------------------------------------------------------------------------
// bst_dp
// Search datapath: range registers, midpoint, table RAM, compare, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_dp #(
  parameter int TABLE_DEPTH = bst_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [bst_pkg::IDX_W-1:0]           entry_index,
  input  wire logic signed [bst_pkg::DATA_W-1:0]   entry_value,
  input  wire logic signed [bst_pkg::DATA_W-1:0]   search_key,
  input  wire logic [bst_pkg::IDX_W-1:0]           range_first,
  input  wire logic signed [bst_pkg::LAST_W-1:0]   range_last,
  input  wire bst_pkg::bst_cmd_t                   cmd,
  output bst_pkg::bst_sts_t                        sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic [bst_pkg::IDX_W-1:0]                out_position
);

  import bst_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int IW     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;
  localparam logic signed [IW-1:0] LAST_MAX = IW'(TABLE_DEPTH - 1);

  function automatic logic signed [IW-1:0] mid_of(input logic signed [IW-1:0] f,
                                                 input logic signed [IW-1:0] l);
    logic signed [IW:0] s;
    s = {f[IW-1], f} + {l[IW-1], l};
    return s[IW:1];
  endfunction

  logic signed [IW-1:0]     first_r;
  logic signed [IW-1:0]     last_r;
  logic signed [IW-1:0]     mid_r;
  logic signed [DATA_W-1:0] key_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         pos_r;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_pos_r;

  logic signed [IW-1:0]     idx_ext;
  logic signed [IW-1:0]     first_ext;
  logic signed [IW-1:0]     last_ext;
  logic signed [IW-1:0]     last_clamp;
  logic signed [IW-1:0]     first_nxt;
  logic signed [IW-1:0]     last_nxt;
  logic signed [IW-1:0]     mid_nxt;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] entry;
  logic                     ram_we;

  assign idx_ext    = {{(IW-IDX_W){1'b0}}, entry_index};
  assign first_ext  = {{(IW-IDX_W){1'b0}}, range_first};
  assign last_ext   = {{(IW-LAST_W){range_last[LAST_W-1]}}, range_last};
  assign last_clamp = (last_ext > LAST_MAX) ? LAST_MAX : last_ext;
  assign ram_we     = cmd.wr && (idx_ext <= LAST_MAX);

  assign entry      = $signed(rdata);

  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    if (key_r < entry) begin
      last_nxt = mid_r - IW'(1);
    end else begin
      first_nxt = mid_r + IW'(1);
    end
  end

  assign mid_nxt = cmd.step ? mid_of(first_nxt, last_nxt) : mid_of(first_r, last_r);

  assign sts.range_ok = (first_r <= last_r);
  assign sts.match    = (entry == key_r);
  assign sts.next_ok  = (first_nxt <= last_nxt);
  assign sts.out_free = !out_valid_r || out_ready;

  bst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[ADDR_W-1:0]),
    .wdata (entry_value),
    .re    (cmd.issue),
    .raddr (mid_nxt[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= first_ext;
      last_r  <= last_clamp;
      key_r   <= search_key;
    end else if (cmd.step) begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
    if (cmd.issue) begin
      mid_r <= mid_nxt;
    end
    if (cmd.hit) begin
      hit_r <= 1'b1;
      pos_r <= mid_r[IDX_W-1:0];
    end else if (cmd.miss) begin
      hit_r <= 1'b0;
      pos_r <= '0;
    end
    if (cmd.emit) begin
      out_found_r <= hit_r;
      out_pos_r   <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

`default_nettype wire

/* rtl/core/binary_search_table.sv */
// ----------------------------------------------------------------------------
// binary_search_table
// Table of signed 32-bit entries with binary search over an index range.
//
//   channel  dir  payload                                         role
//   in_ch    in   func, entry_index, entry_value, search_key,    write or search
//                 range_first, range_last
//   out_ch   out  found, position                                 one per search
//
// A write is stored through the table port at the accepting edge.
// A search keeps the block busy until its result is moved out; it makes at most
// 11 probes for a 1024-entry range, each probe being one RAM read and compare.
// Reset clears control only; table contents are undefined until written.
// A finished result waits in the block while the output register is full;
// the next transaction is accepted once it has moved to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_search_table #(
  parameter int TABLE_DEPTH = bst_pkg::TABLE_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  bst_in_if.sink   in_ch,
  bst_out_if.source out_ch
);

  import bst_pkg::*;

  bst_cmd_t cmd;
  bst_sts_t sts;

  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_index  (in_ch.entry_index),
    .entry_value  (in_ch.entry_value),
    .search_key   (in_ch.search_key),
    .range_first  (in_ch.range_first),
    .range_last   (in_ch.range_last),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_position (out_ch.position)
  );

  // write transactions never produce a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.func == FUNC_WRITE) && !out_ch.valid)
    |=> !out_ch.valid)
    else $error("result after write transaction");

  // a search holds off further input
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.func == FUNC_SEARCH)) |=> !in_ch.ready)
    else $error("input accepted during search");

  // a new result only appears while a search was in progress
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("result without search");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.position == '0))
    else $error("nonzero position on miss");

endmodule

`default_nettype wire
